// ----- src/rss_pkg.sv -----
// Shared types and constants of the range scan segmenter.
// No dependencies; every other file of the block imports this package.
package rss_pkg;

    // Scan geometry and field widths
    localparam int SCAN_POINTS = 2048;
    localparam int IDX_W       = 11;
    localparam int CNT_W       = 12;
    localparam int RANGE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MINP_W      = 12;

    localparam logic [IDX_W-1:0] BEAM_MAX  = IDX_W'(SCAN_POINTS - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SCAN_POINTS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS = 2'd2;

    // Configuration reset values
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 16'd8000;
    localparam logic [RANGE_W-1:0] MAX_DELTA_RST  = 16'd500;
    localparam logic [MINP_W-1:0]  MIN_POINTS_RST = 12'd5;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One range sample request
    typedef struct packed {
        logic [RANGE_W-1:0] range_sample;
        logic               scan_last;
    } t_item;

    // One segment report
    typedef struct packed {
        logic [IDX_W-1:0]   start_index;
        logic [IDX_W-1:0]   end_index;
        logic [CNT_W-1:0]   point_count;
        logic [RANGE_W-1:0] range_before;
        logic               before_known;
        logic [RANGE_W-1:0] range_after;
        logic               after_known;
        logic               last_of_item;
    } t_result;

    // Results produced by one sample, handed to the queue
    typedef struct packed {
        logic    push_one;
        logic    push_two;
        t_result first;
        t_result second;
    } t_push;

endpackage

// ----- src/rss_ifs.sv -----
// Channel interfaces of the range scan segmenter: sample, report and config.
// Depends on rss_pkg for the field widths.
interface rss_in_if;
    import rss_pkg::*;
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_sample;
    logic               scan_last;
    modport source (output valid, range_sample, scan_last, input ready);
    modport sink   (input valid, range_sample, scan_last, output ready);
endinterface

interface rss_out_if;
    import rss_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   start_index;
    logic [IDX_W-1:0]   end_index;
    logic [CNT_W-1:0]   point_count;
    logic [RANGE_W-1:0] range_before;
    logic               before_known;
    logic [RANGE_W-1:0] range_after;
    logic               after_known;
    logic               last_of_item;
    modport source (output valid, start_index, end_index, point_count, range_before,
                    before_known, range_after, after_known, last_of_item, input ready);
    modport sink   (input valid, start_index, end_index, point_count, range_before,
                    before_known, range_after, after_known, last_of_item, output ready);
endinterface

interface rss_cfg_if;
    import rss_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/range_scan_segmenter_unit.sv -----
// Range scan segmenter: jump-distance segmentation of laser range scans.
// Channels: i_in takes one range sample request per accept (range_sample,
// scan_last); o_out gives segment reports; i_cfg writes max_range (index 0),
// max_range_delta (index 1) and min_points (index 2), and is always ready.
// Only write config while no sample or report is in flight.
// An accepted sample is registered, then processed into the result queue once
// the queue has room; its first report is valid on o_out once it is queued.
// Throughput: one sample per cycle. A sample that both closes a segment and
// ends the scan yields two reports, which leave one per cycle, while the
// receiver is ready, from a four-entry result queue; the processing step
// stalls while the queue has fewer than two free entries.
// Reset (synchronous, i_rst_n low) loads the config defaults 8000 / 500 / 5,
// empties the queue and starts a new scan at beam 0.
// When the receiver stalls, reports wait in the queue, the input register
// then holds its sample, and i_in.ready drops until space frees up.
// Depends on rss_pkg, rss_ifs, rss_in_stage, rss_seg_core, rss_res_queue.
module range_scan_segmenter_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rss_in_if.sink       i_in,
    rss_cfg_if.sink      i_cfg,
    rss_out_if.source    o_out
);
    import rss_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    take;
    logic    room;
    t_push   push;
    t_result head;

    assign in_item.range_sample = i_in.range_sample;
    assign in_item.scan_last    = i_in.scan_last;
    assign i_cfg.ready          = 1'b1;

    rss_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (i_in.ready),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    rss_seg_core u_seg_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_room       (room),
        .o_take       (take),
        .o_push       (push)
    );

    rss_res_queue u_res_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out.valid),
        .o_result (head),
        .i_ready  (o_out.ready)
    );

    // Report fields
    assign o_out.start_index  = head.start_index;
    assign o_out.end_index    = head.end_index;
    assign o_out.point_count  = head.point_count;
    assign o_out.range_before = head.range_before;
    assign o_out.before_known = head.before_known;
    assign o_out.range_after  = head.range_after;
    assign o_out.after_known  = head.after_known;
    assign o_out.last_of_item = head.last_of_item;

endmodule

// ----- src/rss_in_stage.sv -----
// Input register of the range scan segmenter: holds one sample request.
// Depends on rss_pkg.
module rss_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rss_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output rss_pkg::t_item o_item,
    input  logic           i_take
);
    import rss_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held sample is consumed this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/rss_seg_core.sv -----
// Segmentation state and config registers: one sample per cycle while the queue has room, up to two reports.
// Depends on rss_pkg.
module rss_seg_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [rss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_item_valid,
    input  rss_pkg::t_item                 i_item,
    input  logic                           i_room,
    output logic                           o_take,
    output rss_pkg::t_push                 o_push
);
    import rss_pkg::*;

    // Configuration
    logic [RANGE_W-1:0] r_max_range;
    logic [RANGE_W-1:0] r_max_delta;
    logic [MINP_W-1:0]  r_min_points;

    // Scan and open segment state
    logic [RANGE_W-1:0] r_prev;
    logic [IDX_W-1:0]   r_beam;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_start;
    logic [IDX_W-1:0]   r_end;
    logic [RANGE_W-1:0] r_before;
    logic               r_known;

    logic [RANGE_W-1:0] n_prev;
    logic [IDX_W-1:0]   n_beam;
    logic [CNT_W-1:0]   n_cnt;
    logic [IDX_W-1:0]   n_start;
    logic [IDX_W-1:0]   n_end;
    logic [RANGE_W-1:0] n_before;
    logic               n_known;

    logic [RANGE_W-1:0] sample;
    logic               in_range;
    logic               first_beam;
    logic [RANGE_W-1:0] diff;
    logic               brk;
    logic [CNT_W-1:0]   cnt_kept;
    logic [CNT_W-1:0]   cnt_grown;
    logic               emit_break;
    logic               emit_flush;
    t_result            seg_break;
    t_result            seg_flush;

    assign o_take = i_item_valid && i_room;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range  <= MAX_RANGE_RST;
            r_max_delta  <= MAX_DELTA_RST;
            r_min_points <= MIN_POINTS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_RANGE:  r_max_range  <= i_cfg_data;
                CFG_MAX_DELTA:  r_max_delta  <= i_cfg_data;
                CFG_MIN_POINTS: r_min_points <= i_cfg_data[MINP_W-1:0];
                default: ;
            endcase
        end
    end

    // Break decision between this sample and the previous one
    assign sample     = i_item.range_sample;
    assign in_range   = sample < r_max_range;
    assign first_beam = r_beam == '0;
    assign diff       = (sample >= r_prev) ? (sample - r_prev) : (r_prev - sample);
    assign brk        = !in_range || (r_prev >= r_max_range) || (diff > r_max_delta);

    // Open segment closes on a break; the first beam always starts fresh
    assign cnt_kept   = (first_beam || brk) ? '0 : r_cnt;
    assign emit_break = !first_beam && brk && (r_cnt != '0)
                        && (r_cnt >= r_min_points);
    assign cnt_grown  = (cnt_kept < CNT_LIMIT) ? cnt_kept + 1'b1 : cnt_kept;

    // Next segment state after adding this sample
    always_comb begin
        n_cnt    = cnt_kept;
        n_start  = r_start;
        n_end    = r_end;
        n_before = r_before;
        n_known  = r_known;
        if (in_range) begin
            n_cnt = cnt_grown;
            n_end = r_beam;
            if (cnt_grown == CNT_W'(1)) begin
                n_start  = r_beam;
                n_before = first_beam ? '0 : r_prev;
                n_known  = !first_beam;
            end
        end
    end

    assign emit_flush = i_item.scan_last && (n_cnt != '0) && (n_cnt >= r_min_points);

    // Report of the segment closed by this sample
    always_comb begin
        seg_break.start_index  = r_start;
        seg_break.end_index    = r_end;
        seg_break.point_count  = r_cnt;
        seg_break.range_before = r_known ? r_before : '0;
        seg_break.before_known = r_known;
        seg_break.range_after  = sample;
        seg_break.after_known  = 1'b1;
        seg_break.last_of_item = !emit_flush;
    end

    // Report of the segment flushed at scan end
    always_comb begin
        seg_flush.start_index  = n_start;
        seg_flush.end_index    = n_end;
        seg_flush.point_count  = n_cnt;
        seg_flush.range_before = n_known ? n_before : '0;
        seg_flush.before_known = n_known;
        seg_flush.range_after  = '0;
        seg_flush.after_known  = 1'b0;
        seg_flush.last_of_item = 1'b1;
    end

    always_comb begin
        o_push.push_one = o_take && (emit_break || emit_flush);
        o_push.push_two = o_take && emit_break && emit_flush;
        o_push.first    = emit_break ? seg_break : seg_flush;
        o_push.second   = seg_flush;
    end

    // Scan position wraps at scan end and saturates otherwise
    assign n_beam = i_item.scan_last ? '0 : ((r_beam < BEAM_MAX) ? r_beam + 1'b1 : r_beam);
    assign n_prev = i_item.scan_last ? '0 : sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_beam   <= '0;
            r_cnt    <= '0;
            r_start  <= '0;
            r_end    <= '0;
            r_before <= '0;
            r_known  <= 1'b0;
        end else if (o_take) begin
            r_prev   <= n_prev;
            r_beam   <= n_beam;
            r_cnt    <= i_item.scan_last ? '0 : n_cnt;
            r_start  <= n_start;
            r_end    <= n_end;
            r_before <= n_before;
            r_known  <= n_known;
        end
    end

endmodule

// ----- src/rss_res_queue.sv -----
// Result queue of the range scan segmenter: takes up to two reports a cycle,
// hands out one while the receiver is ready. Depends on rss_pkg.
module rss_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rss_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    output rss_pkg::t_result o_result,
    input  logic             i_ready
);
    import rss_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_head;
    logic [QPTR_W-1:0]   r_tail;
    logic [QCNT_W-1:0]   r_count;
    logic                pop;
    logic [QPTR_W-1:0]   tail_next;
    logic [QCNT_W-1:0]   push_n;

    // Room for a worst-case sample of two reports
    assign o_room    = r_count <= QCNT_W'(QUEUE_DEPTH - 2);
    assign o_valid   = r_count != '0;
    assign pop       = o_valid && i_ready;
    assign tail_next = r_tail + 1'b1;
    assign push_n    = i_push.push_two ? QCNT_W'(2)
                     : (i_push.push_one ? QCNT_W'(1) : QCNT_W'(0));

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.push_one) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.push_two) begin
            r_mem[tail_next] <= i_push.second;
        end
    end

    // Head read
    assign o_result = r_mem[r_head];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + push_n[QPTR_W-1:0];
            r_count <= r_count + push_n - QCNT_W'(pop);
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
        end
    end

endmodule
